[design/fdfu_pkg.sv]
// Shared constants, types and arithmetic helpers for the 1-D FDTD field update block.
`timescale 1ns / 1ps

package fdfu_pkg;

    // Grid size and derived widths
    localparam int CELLS = 2048;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = AW + 1;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_H_COEF      = 3'd0;
    localparam logic [2:0] REG_E_COEF      = 3'd1;
    localparam logic [2:0] REG_LEFT_ABSORB = 3'd2;
    localparam logic [2:0] REG_RIGHT_ABSORB = 3'd3;
    localparam logic [2:0] REG_SOURCE_CELL = 3'd4;

    // Input command codes
    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // One memory write
    typedef struct packed {
        logic                 en;
        logic [AW-1:0]        addr;
        logic signed [31:0]   data;
    } t_wr;

    // Q1.16 times difference product, rounded half up, back to Q15.16 scale
    function automatic logic signed [35:0] rnd_q16(input logic signed [50:0] p);
        logic signed [51:0] s;
        s = 52'(p) + 52'sd32768;
        return s[51:16];
    endfunction

    // Saturate a grown sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

[design/fdfu_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module fdfu_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/fdfu_sweep_pipe.sv]
// Fused magnetic/electric update pipeline: one cell per cycle, six stages.
`timescale 1ns / 1ps

module fdfu_sweep_pipe (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // read data of old e[k] and h[k], k = 0..CELLS
    input  logic                       i_v,
    input  logic [fdfu_pkg::CW-1:0]    i_k,
    input  logic signed [31:0]         i_e_rd,
    input  logic signed [31:0]         i_h_rd,
    // coefficients and sources
    input  logic signed [17:0]         i_h_coef,
    input  logic signed [17:0]         i_e_coef,
    input  logic signed [31:0]         i_h_src,
    input  logic signed [31:0]         i_e_src,
    input  logic                       i_h_src_en,
    input  logic [fdfu_pkg::AW-1:0]    i_h_src_idx,
    input  logic                       i_e_src_en,
    input  logic [fdfu_pkg::AW-1:0]    i_e_src_idx,
    // write-back
    output fdfu_pkg::t_wr              o_h_wr,
    output logic                       o_e_v,
    output logic [fdfu_pkg::AW-1:0]    o_e_j,
    output logic signed [31:0]         o_e_val
);

    localparam logic [fdfu_pkg::AW-1:0] LAST = fdfu_pkg::AW'(fdfu_pkg::CELLS - 1);

    logic signed [31:0] r_e_prev, r_h_prev, r_hn_last;

    logic                    r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [fdfu_pkg::AW-1:0] r1_j, r2_j, r3_j, r4_j, r5_j, r6_j;
    logic signed [32:0]      r1_d, r4_d;
    logic signed [31:0]      r1_hold, r2_hold;
    logic signed [31:0]      r1_eold, r2_eold, r3_eold, r4_eold, r5_eold;
    logic signed [50:0]      r2_p, r5_p;
    logic signed [31:0]      r3_hn, r6_en;

    logic [fdfu_pkg::AW-1:0] s1_j;
    logic signed [31:0]      n_hn, s3_h0, n_en, s6_e0;

    assign s1_j = fdfu_pkg::AW'(i_k - fdfu_pkg::CW'(1));

    // Magnetic value with optional source subtraction
    always_comb begin
        s3_h0 = fdfu_pkg::sat32(38'(r2_hold) + 38'(fdfu_pkg::rnd_q16(r2_p)));
        n_hn  = s3_h0;
        if (i_h_src_en && r2_j == i_h_src_idx) begin
            n_hn = fdfu_pkg::sat32(38'(s3_h0) - 38'(i_h_src));
        end
    end

    // Electric value with optional source addition
    always_comb begin
        s6_e0 = fdfu_pkg::sat32(38'(r5_eold) + 38'(fdfu_pkg::rnd_q16(r5_p)));
        n_en  = s6_e0;
        if (i_e_src_en && r5_j == i_e_src_idx) begin
            n_en = fdfu_pkg::sat32(38'(s6_e0) + 38'(i_e_src));
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r1_v <= i_v && (i_k != '0);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_v) begin
            r_e_prev <= i_e_rd;
            r_h_prev <= i_h_rd;
        end
        // stage 1: e difference, last magnetic cell has no update
        r1_j    <= s1_j;
        r1_d    <= (s1_j == LAST) ? 33'sd0 : (33'(i_e_rd) - 33'(r_e_prev));
        r1_hold <= r_h_prev;
        r1_eold <= r_e_prev;
        // stage 2: magnetic product
        r2_j    <= r1_j;
        r2_p    <= 51'(i_h_coef) * 51'(r1_d);
        r2_hold <= r1_hold;
        r2_eold <= r1_eold;
        // stage 3: new magnetic value
        r3_j    <= r2_j;
        r3_hn   <= n_hn;
        r3_eold <= r2_eold;
        if (r3_v) begin
            r_hn_last <= r3_hn;
        end
        // stage 4: h difference
        r4_j    <= r3_j;
        r4_d    <= 33'(r3_hn) - 33'(r_hn_last);
        r4_eold <= r3_eold;
        // stage 5: electric product
        r5_j    <= r4_j;
        r5_p    <= 51'(i_e_coef) * 51'(r4_d);
        r5_eold <= r4_eold;
        // stage 6: new electric value
        r6_j    <= r5_j;
        r6_en   <= n_en;
    end

    assign o_h_wr.en   = r3_v;
    assign o_h_wr.addr = r3_j;
    assign o_h_wr.data = r3_hn;
    assign o_e_v       = r6_v;
    assign o_e_j       = r6_j;
    assign o_e_val     = r6_en;

endmodule

[design/fdtd_1d_field_update.sv]
// Top level: 1-D Yee FDTD grid with first-order Mur boundaries, memory-based sweep.
//
//  channel   direction  fields
//  s_axis    in         tuser: cmd; tdata: h_source, e_source, cell_index
//  m_axis    out        tdata: e_value, h_value, e_min, e_max
//  cfg       in         wr_en, addr (register index), wdata
//
//  Step: the sweep reads every cell through the single read port of each field memory
//  into the six pipeline stages, then the boundary states BND_L, BND_R, BND_W and DONE.
//  Read: a memory read, then a load of the result register once it is free.
//  After reset a clearing pass writes zero to all CELLS entries; no item is taken
//  then. A stalled result holds the block before it returns to idle.
`timescale 1ns / 1ps

module fdtd_1d_field_update (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [79:0]   s_axis_tdata,   // h_source[31:0], e_source[63:32], cell_index[74:64]
    input  logic          s_axis_tuser,   // cmd
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // e_value, h_value, e_min, e_max
    input  logic          i_cfg_wr_en,
    input  logic [2:0]    i_cfg_addr,
    input  logic [17:0]   i_cfg_wdata
);

    localparam int AW = fdfu_pkg::AW;
    localparam int CW = fdfu_pkg::CW;
    localparam logic [CW-1:0] N_CNT  = CW'(fdfu_pkg::CELLS);
    localparam logic [CW-1:0] K_ONE  = CW'(1);
    localparam logic [CW-1:0] K_NM2  = CW'(fdfu_pkg::CELLS - 2);
    localparam logic [CW-1:0] K_NM1  = CW'(fdfu_pkg::CELLS - 1);
    localparam logic [AW-1:0] J_ONE  = AW'(1);
    localparam logic [AW-1:0] J_NM2  = AW'(fdfu_pkg::CELLS - 2);
    localparam logic [AW-1:0] J_NM1  = AW'(fdfu_pkg::CELLS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_SWEEP, ST_DRAIN,
        ST_BND_L, ST_BND_R, ST_BND_W, ST_DONE
    } t_state;

    t_state r_state;

    // Configuration registers
    logic signed [17:0] r_h_coef, r_e_coef, r_left, r_right;
    logic [10:0]        r_src_cell;

    // Step context
    logic signed [31:0] r_h_src, r_e_src;
    logic               r_h_src_en, r_e_src_en;
    logic [AW-1:0]      r_h_src_idx, r_e_src_idx;
    logic [CW-1:0]      r_k;
    logic               r_sv;
    logic [CW-1:0]      r_sk;
    logic               r_rd_ok;
    logic signed [31:0] r_oe0, r_oe1, r_oen2, r_oen1, r_ne1, r_nen2;
    logic signed [31:0] r_lo, r_hi;
    logic signed [50:0] r_bp;

    // Output register
    logic               r_ovalid;
    logic [127:0]       r_odata;

    logic               s_acc, out_free, out_load;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic signed [31:0] e_dout, h_dout;
    fdfu_pkg::t_wr      e_wr, h_wr, pipe_h_wr;
    logic               pe_v;
    logic [AW-1:0]      pe_j;
    logic signed [31:0] pe_val;
    logic signed [31:0] bnd_val;
    logic               idx_ok;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_ovalid || m_axis_tready;
    assign out_load      = out_free && (r_state == ST_RD_WAIT || r_state == ST_DONE);
    assign idx_ok        = 32'(s_axis_tdata[74:64]) < 32'(fdfu_pkg::CELLS);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_coef   <= 18'sd65536;
            r_e_coef   <= 18'sd65536;
            r_left     <= 18'sd0;
            r_right    <= 18'sd0;
            r_src_cell <= 11'd10;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                fdfu_pkg::REG_H_COEF:       r_h_coef   <= i_cfg_wdata;
                fdfu_pkg::REG_E_COEF:       r_e_coef   <= i_cfg_wdata;
                fdfu_pkg::REG_LEFT_ABSORB:  r_left     <= i_cfg_wdata;
                fdfu_pkg::REG_RIGHT_ABSORB: r_right    <= i_cfg_wdata;
                fdfu_pkg::REG_SOURCE_CELL:  r_src_cell <= i_cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // Memory read port select
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_k[AW-1:0];
        if (r_state == ST_IDLE) begin
            rd_en   = s_acc && (s_axis_tuser == fdfu_pkg::CMD_READ) && idx_ok;
            rd_addr = AW'(32'(s_axis_tdata[74:64]));
        end else if (r_state == ST_SWEEP) begin
            rd_en = r_k < N_CNT;
        end
    end

    // Boundary value: left in BND_R, right in BND_W
    always_comb begin
        if (r_state == ST_BND_R) begin
            bnd_val = fdfu_pkg::sat32(38'(r_oe1) + 38'(fdfu_pkg::rnd_q16(r_bp)));
        end else begin
            bnd_val = fdfu_pkg::sat32(38'(r_oen2) + 38'(fdfu_pkg::rnd_q16(r_bp)));
        end
    end

    // Electric memory write select
    always_comb begin
        e_wr.en   = 1'b0;
        e_wr.addr = r_k[AW-1:0];
        e_wr.data = 32'sd0;
        if (r_state == ST_CLEAR) begin
            e_wr.en = 1'b1;
        end else if (r_state == ST_BND_R) begin
            e_wr.en   = 1'b1;
            e_wr.addr = '0;
            e_wr.data = bnd_val;
        end else if (r_state == ST_BND_W) begin
            e_wr.en   = 1'b1;
            e_wr.addr = J_NM1;
            e_wr.data = bnd_val;
        end else begin
            e_wr.en   = pe_v && (pe_j != J_NM1);
            e_wr.addr = pe_j;
            e_wr.data = pe_val;
        end
    end

    // Magnetic memory write select
    always_comb begin
        if (r_state == ST_CLEAR) begin
            h_wr.en   = 1'b1;
            h_wr.addr = r_k[AW-1:0];
            h_wr.data = 32'sd0;
        end else begin
            h_wr = pipe_h_wr;
        end
    end

    fdfu_ram #(.DEPTH(fdfu_pkg::CELLS), .WIDTH(32)) u_e_mem (
        .i_clk   (i_clk),
        .i_we    (e_wr.en),
        .i_waddr (e_wr.addr),
        .i_wdata (e_wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (e_dout)
    );

    fdfu_ram #(.DEPTH(fdfu_pkg::CELLS), .WIDTH(32)) u_h_mem (
        .i_clk   (i_clk),
        .i_we    (h_wr.en),
        .i_waddr (h_wr.addr),
        .i_wdata (h_wr.data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (h_dout)
    );

    fdfu_sweep_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_v         (r_sv),
        .i_k         (r_sk),
        .i_e_rd      (e_dout),
        .i_h_rd      (h_dout),
        .i_h_coef    (r_h_coef),
        .i_e_coef    (r_e_coef),
        .i_h_src     (r_h_src),
        .i_e_src     (r_e_src),
        .i_h_src_en  (r_h_src_en),
        .i_h_src_idx (r_h_src_idx),
        .i_e_src_en  (r_e_src_en),
        .i_e_src_idx (r_e_src_idx),
        .o_h_wr      (pipe_h_wr),
        .o_e_v       (pe_v),
        .o_e_j       (pe_j),
        .o_e_val     (pe_val)
    );

    // Sequencer, step context and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_k      <= '0;
            r_sv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_sv <= (r_state == ST_SWEEP);
            r_sk <= r_k;
            if (m_axis_tready && !out_load) begin
                r_ovalid <= 1'b0;
            end

            // old edge values as the sweep reads them
            if (r_sv) begin
                if (r_sk == '0)  r_oe0  <= e_dout;
                if (r_sk == K_ONE) r_oe1  <= e_dout;
                if (r_sk == K_NM2) r_oen2 <= e_dout;
                if (r_sk == K_NM1) r_oen1 <= e_dout;
            end

            // interior results: capture neighbors of the edges, fold extremes;
            // both edge cells are replaced by the boundary values later
            if (pe_v && pe_j != J_NM1) begin
                if (pe_j == J_ONE) r_ne1  <= pe_val;
                if (pe_j == J_NM2) r_nen2 <= pe_val;
                if (pe_j != '0) begin
                    if (pe_val < r_lo) r_lo <= pe_val;
                    if (pe_val > r_hi) r_hi <= pe_val;
                end
            end

            unique case (r_state)
                ST_CLEAR: begin
                    if (r_k == K_NM1) begin
                        r_k     <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_k <= r_k + K_ONE;
                    end
                end
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_axis_tuser == fdfu_pkg::CMD_READ) begin
                            r_rd_ok <= idx_ok;
                            r_state <= ST_RD_WAIT;
                        end else begin
                            r_h_src     <= s_axis_tdata[31:0];
                            r_e_src     <= s_axis_tdata[63:32];
                            r_h_src_en  <= (r_src_cell != 11'd0) &&
                                           (32'(r_src_cell) - 32'd1 < 32'(fdfu_pkg::CELLS));
                            r_h_src_idx <= AW'(32'(r_src_cell) - 32'd1);
                            r_e_src_en  <= 32'(r_src_cell) < 32'(fdfu_pkg::CELLS);
                            r_e_src_idx <= AW'(32'(r_src_cell));
                            r_lo        <= 32'sh7FFF_FFFF;
                            r_hi        <= 32'sh8000_0000;
                            r_k         <= '0;
                            r_state     <= ST_SWEEP;
                        end
                    end
                end
                ST_RD_WAIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {64'd0, r_rd_ok ? h_dout : 32'sd0,
                                     r_rd_ok ? e_dout : 32'sd0};
                        r_state  <= ST_IDLE;
                    end
                end
                ST_SWEEP: begin
                    r_k  <= r_k + K_ONE;
                    if (r_k == N_CNT) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pe_v && pe_j == J_NM1) begin
                        r_state <= ST_BND_L;
                    end
                end
                ST_BND_L: begin
                    r_bp    <= 51'(r_left) * 51'(33'(r_ne1) - 33'(r_oe0));
                    r_state <= ST_BND_R;
                end
                ST_BND_R: begin
                    r_bp <= 51'(r_right) * 51'(33'(r_nen2) - 33'(r_oen1));
                    if (bnd_val < r_lo) r_lo <= bnd_val;
                    if (bnd_val > r_hi) r_hi <= bnd_val;
                    r_state <= ST_BND_W;
                end
                ST_BND_W: begin
                    if (bnd_val < r_lo) r_lo <= bnd_val;
                    if (bnd_val > r_hi) r_hi <= bnd_val;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {r_hi, r_lo, 64'd0};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
